// File: hw/rtl/xz_aws_pkg.sv
// Package for the XZ angle window score core.
// Holds CORDIC constants, the atan table, the stage word type and register codes.
// No dependencies.
package xz_aws_pkg;

  localparam int ANGLE_ITERATIONS = 16;
  localparam int ATAN_LEN         = 24;
  localparam int XW               = 36;
  localparam int ZW               = 28;
  localparam int CFG_W            = 22;

  typedef logic signed [ZW-1:0] ang_acc_t;

  localparam ang_acc_t PI_Q24 = 28'sd52707179;
  localparam logic signed [15:0] PI_Q13 = 16'sd25736;
  localparam logic [15:0] SCORE_ONE = 16'd32768;
  localparam ang_acc_t ROUND_Q13 = 28'sd1024;

  localparam ang_acc_t ATAN_TAB [ATAN_LEN] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214, 28'sd524117,
    28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768, 28'sd16384, 28'sd8192,
    28'sd4096, 28'sd2048, 28'sd1024, 28'sd512, 28'sd256, 28'sd128,
    28'sd64, 28'sd32, 28'sd16, 28'sd8, 28'sd4, 28'sd2
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_word_t;

  typedef enum logic [2:0] {
    REG_REF_X,
    REG_REF_Z,
    REG_MIN_ANGLE,
    REG_MAX_ANGLE,
    REG_INV_SPAN,
    REG_FILTER_EN,
    REG_SCORE_EN
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SC_ONE,
    SC_ZERO,
    SC_RAMP
  } score_sel_t;

endpackage

// File: hw/rtl/xz_aws_pre.sv
// Front end: products of reference and candidate, cross/dot, half-plane fold.
// Two registered stages with local handshake. Depends on xz_aws_pkg.
module xz_aws_pre
  import xz_aws_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic signed [15:0]  fwd_x_i,
  input  logic signed [15:0]  fwd_z_i,
  input  logic signed [15:0]  ref_x_i,
  input  logic signed [15:0]  ref_z_i,
  output logic                valid_o,
  input  logic                ready_i,
  output cordic_word_t        word_o
);

  logic signed [16:0] nrz;
  logic signed [32:0] pa_nxt, pb_nxt, pc_nxt, pd_nxt;
  logic signed [32:0] pa_r, pb_r, pc_r, pd_r;
  logic               v1_r, v2_r;
  logic               load1, load2;
  logic signed [33:0] cross_w, dot_w;
  cordic_word_t       word_nxt, word_r;

  assign load2   = !v2_r || ready_i;
  assign load1   = !v1_r || load2;
  assign ready_o = load1;

  assign nrz    = -{ref_z_i[15], ref_z_i};
  assign pa_nxt = nrz * fwd_x_i;
  assign pb_nxt = ref_x_i * fwd_x_i;
  assign pc_nxt = nrz * fwd_z_i;
  assign pd_nxt = ref_x_i * fwd_z_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (load1) begin
      v1_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
      pc_r <= pc_nxt;
      pd_r <= pd_nxt;
    end
  end

  assign cross_w = {pa_r[32], pa_r} - {pd_r[32], pd_r};
  assign dot_w   = {pc_r[32], pc_r} + {pb_r[32], pb_r};

  always_comb begin
    word_nxt.zero = (cross_w == '0) && (dot_w == '0);
    if (dot_w < 0) begin
      word_nxt.x = -{{(XW-34){dot_w[33]}}, dot_w};
      word_nxt.y = -{{(XW-34){cross_w[33]}}, cross_w};
      word_nxt.z = (cross_w >= 0) ? PI_Q24 : -PI_Q24;
    end else begin
      word_nxt.x = {{(XW-34){dot_w[33]}}, dot_w};
      word_nxt.y = {{(XW-34){cross_w[33]}}, cross_w};
      word_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (load2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      word_r <= word_nxt;
    end
  end

  assign valid_o = v2_r;
  assign word_o  = word_r;

endmodule

// File: hw/rtl/xz_aws_cell.sv
// One vectoring CORDIC iteration with its own stage register and handshake.
// Shift and atan step come in as tie-offs. Depends on xz_aws_pkg.
module xz_aws_cell
  import xz_aws_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic [4:0]    shift_i,
  input  ang_acc_t      atan_i,
  input  logic          valid_i,
  output logic          ready_o,
  input  cordic_word_t  word_i,
  output logic          valid_o,
  input  logic          ready_i,
  output cordic_word_t  word_o
);

  logic                 v_r;
  logic                 load;
  logic signed [XW-1:0] dx, dy;
  cordic_word_t         word_nxt, word_r;

  assign load    = !v_r || ready_i;
  assign ready_o = load;

  assign dx = word_i.y >>> shift_i;
  assign dy = word_i.x >>> shift_i;

  always_comb begin
    word_nxt.zero = word_i.zero;
    if (word_i.y >= 0) begin
      word_nxt.x = word_i.x + dx;
      word_nxt.y = word_i.y - dy;
      word_nxt.z = word_i.z + atan_i;
    end else begin
      word_nxt.x = word_i.x - dx;
      word_nxt.y = word_i.y + dy;
      word_nxt.z = word_i.z - atan_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (load) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word_nxt;
    end
  end

  assign valid_o = v_r;
  assign word_o  = word_r;

endmodule

// File: hw/rtl/xz_aws_post.sv
// Back end: angle rounding and clamp, window test, score ramp, output register.
// Three registered stages with local handshake. Depends on xz_aws_pkg.
module xz_aws_post
  import xz_aws_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  output logic               ready_o,
  input  cordic_word_t       word_i,
  input  logic signed [15:0] min_angle_i,
  input  logic signed [15:0] max_angle_i,
  input  logic [21:0]        inv_span_i,
  input  logic               filter_en_i,
  input  logic               score_en_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic               filtered_o,
  output logic [15:0]        score_o,
  output logic signed [15:0] angle_o
);

  logic               v1_r, v2_r, v3_r;
  logic               load1, load2, load3;
  ang_acc_t           z_rnd;
  logic signed [16:0] z_q13;
  logic signed [15:0] ang_nxt, ang1_r, ang2_r, ang3_r;
  logic               flt_nxt, flt1_r, flt2_r, flt3_r;
  score_sel_t         sel_nxt, sel1_r, sel2_r;
  logic signed [16:0] diff_w;
  logic [15:0]        diff1_r;
  logic [37:0]        prod2_r;
  logic [23:0]        prod_sh;
  logic [15:0]        score_nxt, score3_r;

  assign load3   = !v3_r || ready_i;
  assign load2   = !v2_r || load3;
  assign load1   = !v1_r || load2;
  assign ready_o = load1;

  // round Q.24 to Q2.13, clamp to +-pi
  assign z_rnd = word_i.z + ROUND_Q13;
  assign z_q13 = z_rnd[ZW-1:11];

  always_comb begin
    if (word_i.zero) begin
      ang_nxt = '0;
    end else if (z_q13 > 17'(PI_Q13)) begin
      ang_nxt = PI_Q13;
    end else if (z_q13 < -17'(PI_Q13)) begin
      ang_nxt = -PI_Q13;
    end else begin
      ang_nxt = z_q13[15:0];
    end
  end

  assign flt_nxt = filter_en_i && ((ang_nxt < min_angle_i) || (ang_nxt > max_angle_i));
  assign diff_w  = {ang_nxt[15], ang_nxt} - {min_angle_i[15], min_angle_i};

  always_comb begin
    if (!score_en_i || (ang_nxt >= max_angle_i)) begin
      sel_nxt = SC_ONE;
    end else if (ang_nxt <= min_angle_i) begin
      sel_nxt = SC_ZERO;
    end else begin
      sel_nxt = SC_RAMP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (load1) begin
        v1_r <= valid_i;
      end
      if (load2) begin
        v2_r <= v1_r;
      end
      if (load3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      ang1_r  <= ang_nxt;
      flt1_r  <= flt_nxt;
      sel1_r  <= sel_nxt;
      diff1_r <= diff_w[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      ang2_r  <= ang1_r;
      flt2_r  <= flt1_r;
      sel2_r  <= sel1_r;
      prod2_r <= diff1_r * inv_span_i;
    end
  end

  assign prod_sh = prod2_r[37:14];

  always_comb begin
    case (sel2_r)
      SC_ONE:  score_nxt = SCORE_ONE;
      SC_ZERO: score_nxt = '0;
      SC_RAMP: score_nxt = (prod_sh > {8'd0, SCORE_ONE}) ? SCORE_ONE : prod_sh[15:0];
      default: score_nxt = SCORE_ONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load3) begin
      ang3_r   <= ang2_r;
      flt3_r   <= flt2_r;
      score3_r <= score_nxt;
    end
  end

  assign valid_o    = v3_r;
  assign filtered_o = flt3_r;
  assign score_o    = score3_r;
  assign angle_o    = ang3_r;

endmodule

// File: hw/rtl/xz_angle_window_score_core.sv
// Throughput: one word per cycle while out_ready is high; every stage register has its
// own valid, so bubbles collapse and input is taken while an output word waits.
// Reset (rst_n, synchronous): pipeline emptied, configuration registers to defaults.
// Top level of the XZ angle window score core; uses xz_aws_pkg, xz_aws_pre,
// xz_aws_cell and xz_aws_post.
module xz_angle_window_score_core
  import xz_aws_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_fwd_x,
  input  logic signed [15:0] in_fwd_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_filtered,
  output logic [15:0]        out_score_value,
  output logic signed [15:0] out_angle_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  logic signed [15:0] ref_x_r, ref_z_r, min_angle_r, max_angle_r;
  logic [21:0]        inv_span_r;
  logic               filter_en_r, score_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r     <= 16'sd0;
      ref_z_r     <= -16'sd16384;
      min_angle_r <= -16'sd12868;
      max_angle_r <= 16'sd12868;
      inv_span_r  <= 22'd20861;
      filter_en_r <= 1'b1;
      score_en_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_REF_X:     ref_x_r     <= cfg_wdata[15:0];
        REG_REF_Z:     ref_z_r     <= cfg_wdata[15:0];
        REG_MIN_ANGLE: min_angle_r <= cfg_wdata[15:0];
        REG_MAX_ANGLE: max_angle_r <= cfg_wdata[15:0];
        REG_INV_SPAN:  inv_span_r  <= cfg_wdata[21:0];
        REG_FILTER_EN: filter_en_r <= cfg_wdata[0];
        REG_SCORE_EN:  score_en_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [ANGLE_ITERATIONS:0] cv;
  logic [ANGLE_ITERATIONS:0] cr;
  cordic_word_t              cw [ANGLE_ITERATIONS+1];

  xz_aws_pre u_pre (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid),
    .ready_o (in_ready),
    .fwd_x_i (in_fwd_x),
    .fwd_z_i (in_fwd_z),
    .ref_x_i (ref_x_r),
    .ref_z_i (ref_z_r),
    .valid_o (cv[0]),
    .ready_i (cr[0]),
    .word_o  (cw[0])
  );

  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cell
    xz_aws_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift_i (5'(i)),
      .atan_i  (ATAN_TAB[i]),
      .valid_i (cv[i]),
      .ready_o (cr[i]),
      .word_i  (cw[i]),
      .valid_o (cv[i+1]),
      .ready_i (cr[i+1]),
      .word_o  (cw[i+1])
    );
  end

  xz_aws_post u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_i     (cv[ANGLE_ITERATIONS]),
    .ready_o     (cr[ANGLE_ITERATIONS]),
    .word_i      (cw[ANGLE_ITERATIONS]),
    .min_angle_i (min_angle_r),
    .max_angle_i (max_angle_r),
    .inv_span_i  (inv_span_r),
    .filter_en_i (filter_en_r),
    .score_en_i  (score_en_r),
    .valid_o     (out_valid),
    .ready_i     (out_ready),
    .filtered_o  (out_filtered),
    .score_o     (out_score_value),
    .angle_o     (out_angle_out)
  );

endmodule
